@@ hw/rtl/fxc_pkg.sv @@
// Shared types and constants for the line framer with slice XOR checks.
// Used by every module of the framer; depends on nothing else.

package fxc_pkg;

    localparam logic [7:0] START_BYTE    = 8'h0D;
    localparam logic [7:0] END_BYTE      = 8'h0A;
    localparam logic [7:0] SPOILED_START = 8'h20;

    // A finished check always has bit 6 set: values below 64 get 64 added.
    localparam logic [6:0] CHECK_FLOOR = 7'h40;
    localparam int SLICE_LEN = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOIL_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OMIT_END     = 2'd2;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [6:0] char_in;
        logic       char_last;
    } char_beat_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       frame_last;
        logic       too_long;
    } line_beat_t;

    typedef struct packed {
        logic check_enable;
        logic spoil_start;
        logic omit_end;
    } cfg_t;

    // One job per accepted character that produces at least one byte.
    typedef struct packed {
        logic       send_start;
        logic [7:0] start_byte;
        logic       send_char;
        logic [6:0] char_in;
        logic       last;
        logic       send_checks;
        logic       send_end;
        logic       too_long;
    } job_t;

endpackage

@@ hw/rtl/fxc_front.sv @@
// Front end of the framer: accepts characters, tracks the frame and slice
// state, writes finished checks and queues one job per character. Uses fxc_pkg.

module fxc_front
    import fxc_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      char_valid,
    output logic                      char_ready,
    input  char_beat_t                char_data,
    input  cfg_t                      cfg,
    output logic                      job_valid,
    input  logic                      job_ready,
    output job_t                      job,
    output logic                      stack_we,
    output logic [$clog2((MAX_PAYLOAD+7)/8 > 1 ? (MAX_PAYLOAD+7)/8 : 2)-1:0] stack_addr,
    output logic [6:0]                stack_wdata,
    output logic [$clog2((MAX_PAYLOAD+7)/8 + 1)-1:0] drain_slices,
    input  logic                      drain_done
);

    localparam int STACK_DEPTH = (MAX_PAYLOAD + 7) / 8;
    localparam int SAW = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);
    localparam int SW  = $clog2(STACK_DEPTH + 1);
    localparam int CW  = $clog2(MAX_PAYLOAD + 1);

    logic          in_frame_reg;
    logic [6:0]    xor_reg, xor_next;
    logic [2:0]    pos_reg, pos_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;
    logic [SW-1:0] slices_reg, slices_next;

    logic          accept;
    logic          take;
    logic          last;
    logic          has_bytes;
    logic [CW:0]   count_round;
    logic [CW-1:0] idx_full;

    assign char_ready = job_ready && !busy_reg;
    assign accept     = char_valid && char_ready;
    assign last       = char_data.char_last;
    assign take       = count_reg < CW'(MAX_PAYLOAD);

    always_comb
    begin
        xor_next    = take ? (xor_reg ^ char_data.char_in) : xor_reg;
        count_next  = take ? (count_reg + 1'b1) : count_reg;
        pos_next    = take ? (pos_reg + 3'd1) : pos_reg;
        ovf_next    = ovf_reg || !take;

        // A slice closes when its eighth character arrives, or early on the
        // final character.
        stack_we    = accept && ((take && pos_next == 3'd0) || (last && pos_next != 3'd0));
        idx_full    = (count_next - 1'b1) >> 3;
        stack_addr  = SAW'(idx_full);
        stack_wdata = xor_next | CHECK_FLOOR;

        count_round = {1'b0, count_next} + (CW+1)'(SLICE_LEN - 1);

        job.send_start  = !in_frame_reg;
        job.start_byte  = cfg.spoil_start ? SPOILED_START : START_BYTE;
        job.send_char   = take;
        job.char_in     = char_data.char_in;
        job.last        = last;
        job.send_checks = last && cfg.check_enable;
        job.send_end    = last && !cfg.omit_end;
        job.too_long    = last && ovf_next;

        has_bytes = job.send_start || job.send_char || job.send_checks || job.send_end;
        job_valid = accept && has_bytes;

        busy_next   = busy_reg;
        slices_next = slices_reg;
        if (drain_done)
        begin
            busy_next = 1'b0;
        end
        if (accept && last && has_bytes)
        begin
            busy_next   = 1'b1;
            slices_next = SW'(count_round >> 3);
        end
    end

    assign drain_slices = slices_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            xor_reg      <= '0;
            pos_reg      <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            busy_reg     <= 1'b0;
            slices_reg   <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            slices_reg <= slices_next;
            if (accept)
            begin
                if (last)
                begin
                    in_frame_reg <= 1'b0;
                    xor_reg      <= '0;
                    pos_reg      <= '0;
                    count_reg    <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    in_frame_reg <= 1'b1;
                    xor_reg      <= (pos_next == 3'd0) ? 7'd0 : xor_next;
                    pos_reg      <= pos_next;
                    count_reg    <= count_next;
                    ovf_reg      <= ovf_next;
                end
            end
        end
    end

endmodule

@@ hw/rtl/fxc_queue.sv @@
// Short job queue between the framer's front and back ends.
// Uses job_t and the depth constants from fxc_pkg.

module fxc_queue
    import fxc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0] fill_reg;
    logic                do_push, do_pop;

    assign push_ready = fill_reg != QUEUE_CW'(QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/fxc_back.sv @@
// Back end of the framer: takes jobs from the queue and sends their bytes,
// draining the check stack last slice first. Uses fxc_pkg.

module fxc_back
    import fxc_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  job_t                      job,
    input  logic                      stack_we,
    input  logic [$clog2((MAX_PAYLOAD+7)/8 > 1 ? (MAX_PAYLOAD+7)/8 : 2)-1:0] stack_addr,
    input  logic [6:0]                stack_wdata,
    input  logic [$clog2((MAX_PAYLOAD+7)/8 + 1)-1:0] drain_slices,
    output logic                      drain_done,
    output logic                      line_valid,
    input  logic                      line_ready,
    output line_beat_t                line_data
);

    localparam int STACK_DEPTH = (MAX_PAYLOAD + 7) / 8;
    localparam int SAW = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);
    localparam int SW  = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_START,
        PH_CHAR,
        PH_CHECK,
        PH_END
    } phase_t;

    logic [6:0]     stack_mem [STACK_DEPTH];
    logic [6:0]     rd_data_reg;
    logic [SAW-1:0] rd_addr;

    logic           busy_reg, busy_next;
    job_t           job_reg, job_next;
    phase_t         phase_reg, phase_next;
    logic [SAW-1:0] idx_reg, idx_next;
    logic           out_valid_reg, out_valid_next;
    line_beat_t     out_reg, out_next;

    logic           can_load, emit, pop;
    logic           more_check, later_char, later_check, later_end, byte_final;
    logic [SW-1:0]  top_slice;
    logic [7:0]     cur_byte;

    assign can_load  = !out_valid_reg || line_ready;
    assign emit      = busy_reg && can_load;
    assign pop       = !busy_reg && job_valid;
    assign job_ready = !busy_reg;
    assign top_slice = drain_slices - 1'b1;

    always_comb
    begin
        more_check  = phase_reg == PH_CHECK && idx_reg != '0;
        later_char  = phase_reg == PH_START && job_reg.send_char;
        later_check = (phase_reg == PH_START || phase_reg == PH_CHAR) && job_reg.send_checks;
        later_end   = phase_reg != PH_END && job_reg.send_end;
        byte_final  = !more_check && !later_char && !later_check && !later_end;

        unique case (phase_reg)
            PH_START: cur_byte = job_reg.start_byte;
            PH_CHAR:  cur_byte = {1'b0, job_reg.char_in};
            PH_CHECK: cur_byte = {1'b0, rd_data_reg};
            PH_END:   cur_byte = END_BYTE;
            default:  cur_byte = END_BYTE;
        endcase

        busy_next      = busy_reg;
        job_next       = job_reg;
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !line_ready;
        out_next       = out_reg;

        if (pop)
        begin
            busy_next = 1'b1;
            job_next  = job;
            priority if (job.send_start)
            begin
                phase_next = PH_START;
            end
            else if (job.send_char)
            begin
                phase_next = PH_CHAR;
            end
            else if (job.send_checks)
            begin
                phase_next = PH_CHECK;
                idx_next   = SAW'(top_slice);
            end
            else
            begin
                phase_next = PH_END;
            end
        end
        else if (emit)
        begin
            out_valid_next      = 1'b1;
            out_next.line_byte  = cur_byte;
            out_next.frame_last = byte_final && job_reg.last;
            out_next.too_long   = byte_final && job_reg.too_long;
            priority if (more_check)
            begin
                idx_next = idx_reg - 1'b1;
            end
            else if (later_char)
            begin
                phase_next = PH_CHAR;
            end
            else if (later_check)
            begin
                phase_next = PH_CHECK;
                idx_next   = SAW'(top_slice);
            end
            else if (later_end)
            begin
                phase_next = PH_END;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Reading at the next index keeps the read data lined up with idx_reg.
    assign rd_addr    = idx_next;
    assign drain_done = emit && byte_final && job_reg.last;

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_addr] <= stack_wdata;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            job_reg       <= '0;
            phase_reg     <= PH_START;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            job_reg       <= job_next;
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign line_valid = out_valid_reg;
    assign line_data  = out_reg;

endmodule

@@ hw/rtl/framer_with_slice_xor_check_unit.sv @@
// Top level of the line framer with per-slice XOR check characters.
// Holds the configuration registers and joins fxc_front, fxc_queue and fxc_back.
//
// The framer takes 7-bit characters on the char channel, one beat each, with
// char_last on the final one, and sends a frame on the line channel: a start
// byte 0x0D (0x20 when spoil_start is set), the characters, then one check per
// eight-character slice when check_enable is set, newest slice first, then the
// end byte 0x0A unless omit_end is set. A check is the XOR of its slice with
// bit 6 forced on. Characters past MAX_PAYLOAD are dropped and the final beat
// of that frame carries too_long. For a character in mid-frame the back end
// first takes its job from the queue and then loads the output register; the
// first character of a frame also sends the start byte ahead of it. The final
// character adds one byte per check and one for the end byte, and a new
// frame is not accepted until that drain has been handed to the output
// register, since the next frame's checks would overwrite stack entries that
// are still to be read. The two-entry job queue lets the character input run
// ahead of the line side.
// Configuration writes take effect at once and are meant to be made while the
// framer is idle.

module framer_with_slice_xor_check_unit
    import fxc_pkg::*;
#(
    parameter int MAX_PAYLOAD = 64
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  char_beat_t           char_data,
    output logic                 line_valid,
    input  logic                 line_ready,
    output line_beat_t           line_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    localparam int STACK_DEPTH = (MAX_PAYLOAD + 7) / 8;
    localparam int SAW = $clog2(STACK_DEPTH > 1 ? STACK_DEPTH : 2);
    localparam int SW  = $clog2(STACK_DEPTH + 1);

    cfg_t           cfg_reg;
    logic           fq_valid, fq_ready, qb_valid, qb_ready;
    job_t           fq_job, qb_job;
    logic           stack_we;
    logic [SAW-1:0] stack_addr;
    logic [6:0]     stack_wdata;
    logic [SW-1:0]  drain_slices;
    logic           drain_done;

    // Writes to an index past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_enable <= 1'b1;
            cfg_reg.spoil_start  <= 1'b0;
            cfg_reg.omit_end     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHECK_ENABLE: cfg_reg.check_enable <= cfg_data;
                CFG_SPOIL_START:  cfg_reg.spoil_start  <= cfg_data;
                CFG_OMIT_END:     cfg_reg.omit_end     <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    fxc_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_data    (char_data),
        .cfg          (cfg_reg),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job),
        .stack_we     (stack_we),
        .stack_addr   (stack_addr),
        .stack_wdata  (stack_wdata),
        .drain_slices (drain_slices),
        .drain_done   (drain_done)
    );

    fxc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    fxc_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (qb_valid),
        .job_ready    (qb_ready),
        .job          (qb_job),
        .stack_we     (stack_we),
        .stack_addr   (stack_addr),
        .stack_wdata  (stack_wdata),
        .drain_slices (drain_slices),
        .drain_done   (drain_done),
        .line_valid   (line_valid),
        .line_ready   (line_ready),
        .line_data    (line_data)
    );

endmodule

@@ hw/rtl/fxc_checker.sv @@
// Port-level checks for the framer, bound to its top level.
// Uses fxc_pkg; attaches to framer_with_slice_xor_check_unit.

module fxc_checker
    import fxc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 char_valid,
    input logic                 char_ready,
    input char_beat_t           char_data,
    input logic                 line_valid,
    input logic                 line_ready,
    input line_beat_t           line_data
);

    // Set after reset and after each beat that closes a frame.
    logic expect_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_start_reg <= 1'b1;
        end
        else if (line_valid && line_ready)
        begin
            expect_start_reg <= line_data.frame_last;
        end
    end

    // A waiting character beat stays offered with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(char_data))
        else $error("character beat changed while waiting");

    // A stalled line beat keeps its bytes and flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && !line_ready |=> line_valid && $stable(line_data))
        else $error("line beat changed while stalled");

    // The overflow flag only rides on the closing beat of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_valid |-> !line_data.too_long || line_data.frame_last)
        else $error("too_long set on a beat that does not close the frame");

    // The beat after a closed frame opens the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        line_valid && expect_start_reg |->
            line_data.line_byte == START_BYTE || line_data.line_byte == SPOILED_START)
        else $error("frame does not open with a start byte");

endmodule

bind framer_with_slice_xor_check_unit fxc_checker u_fxc_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench for framer_with_slice_xor_check_unit.
// It depends on fxc_pkg and the framer RTL and needs no other files.
`timescale 1ns / 100ps

module testbench;
    import fxc_pkg::*;

    // The framer is built with the default payload limit. That gives eight
    // slices of eight characters, so one frame carries at most eight checks.
    localparam int MAX_PAYLOAD = 64;
    localparam int STACK_DEPTH = (MAX_PAYLOAD + 7) / SLICE_LEN;

    // This index names no register. A write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // The longest drain is eight checks plus the end byte. SETTLE_CYCLES is the
    // settle time before a register write and at the end of the run.
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int PHASE_ITEMS = 40;

    // These are the register settings of the random phases, packed as
    // {check_enable, spoil_start, omit_end}. The run starts from the reset
    // value and ends by returning to it.
    localparam cfg_t PHASE_CFG [7] = '{3'b000, 3'b110, 3'b101, 3'b011, 3'b001,
                                       3'b111, 3'b100};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_ready;
    char_beat_t           char_data = '0;
    logic                 line_valid;
    logic                 line_ready = 1'b0;
    line_beat_t           line_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_CHECK_ENABLE;
    logic                 cfg_data = 1'b0;

    framer_with_slice_xor_check_unit #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_data  (line_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // Each character waiting to be sent can ask the sender to hold it back
    // until every byte already owed by the framer has come out.
    typedef struct {
        char_beat_t beat;
        bit         wait_for_drain;
    } char_item_t;

    char_item_t  chars_to_send[$];
    line_beat_t  line_bytes_due[$];
    int          bytes_due_count = 0;
    int          mismatches = 0;
    int          chars_sent = 0;
    int          send_gap = 0;
    int          line_beats = 0;
    int          ready_wait = 0;
    int          hold_requests = 0;
    int          holds_started = 0;
    int unsigned cycle_count = 0;

    // This is the state of the frame predictor and its copy of the registers.
    // Only the check entries that were written in the current frame are read.
    cfg_t       framer_cfg = 3'b100;
    bit         in_frame = 1'b0;
    logic [6:0] slice_xor = '0;
    logic [2:0] slice_pos = '0;
    int         char_count = 0;
    logic [6:0] check_stack [STACK_DEPTH];
    bit         overflowed = 1'b0;

    function automatic line_beat_t plain_byte(input logic [7:0] value);
        line_beat_t b;
        b = '0;
        b.line_byte = value;
        return b;
    endfunction

    task automatic clear_frame_state();
        in_frame = 1'b0;
        slice_xor = '0;
        slice_pos = '0;
        char_count = 0;
        overflowed = 1'b0;
    endtask

    // This stores the check of the slice that the latest character belongs to.
    // The XOR is only seven bits wide, so adding 64 to a value below 64 is the
    // same as setting bit 6.
    task automatic close_slice();
        check_stack[(char_count - 1) / SLICE_LEN] = slice_xor | CHECK_FLOOR;
        slice_xor = '0;
    endtask

    // This works out the line bytes that one accepted character causes and
    // queues them behind the bytes that are still due.
    task automatic frame_character(input char_beat_t b);
        line_beat_t burst[$];
        line_beat_t tail;
        if (!in_frame)
        begin
            clear_frame_state();
            in_frame = 1'b1;
            burst.push_back(plain_byte(framer_cfg.spoil_start ? SPOILED_START : START_BYTE));
        end
        // A character past the payload limit is neither sent nor checked. It
        // only marks the frame as too long.
        if (char_count < MAX_PAYLOAD)
        begin
            slice_xor ^= b.char_in;
            burst.push_back(plain_byte({1'b0, b.char_in}));
            char_count++;
            slice_pos++;
            if (slice_pos == 0)
                close_slice();
        end
        else
            overflowed = 1'b1;
        if (b.char_last)
        begin
            if (slice_pos != 0)
                close_slice();
            // The checks go out newest slice first.
            if (framer_cfg.check_enable)
                for (int s = (char_count + 7) / SLICE_LEN - 1; s >= 0; s--)
                    burst.push_back(plain_byte({1'b0, check_stack[s]}));
            if (!framer_cfg.omit_end)
                burst.push_back(plain_byte(END_BYTE));
            // A dropped final character with no checks and no end byte leaves
            // nothing to mark, so that frame simply stops.
            if (burst.size() != 0)
            begin
                tail = burst.pop_back();
                tail.frame_last = 1'b1;
                tail.too_long = overflowed;
                burst.push_back(tail);
            end
            clear_frame_state();
        end
        foreach (burst[i])
            line_bytes_due.push_back(burst[i]);
    endtask

    // The head item may go out at once unless it waits for a drain. The count
    // of bytes due is registered, so a drain is never judged at the same edge
    // as the beat just accepted.
    function automatic bit launch_allowed(input bit just_sent);
        if (chars_to_send.size() == 0)
            return 1'b0;
        if (!chars_to_send[0].wait_for_drain)
            return 1'b1;
        return !just_sent && bytes_due_count == 0;
    endfunction

    // The character sender draws a random gap after each beat. In one stretch
    // out of four it sends back to back. When the next beat follows at once,
    // valid simply stays high and only the payload changes.
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        char_item_t next_item;
        int         gap_draw;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_data <= '0;
            send_gap <= 0;
        end
        else if (char_valid && char_ready)
        begin
            chars_sent++;
            gap_draw = ((chars_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
            if (gap_draw == 0 && launch_allowed(1'b1))
            begin
                next_item = chars_to_send.pop_front();
                char_data <= next_item.beat;
            end
            else
            begin
                char_valid <= 1'b0;
                send_gap <= (gap_draw == 0) ? 0 : gap_draw - 1;
            end
        end
        else if (!char_valid)
        begin
            if (send_gap != 0)
                send_gap <= send_gap - 1;
            else if (launch_allowed(1'b0))
            begin
                next_item = chars_to_send.pop_front();
                char_valid <= 1'b1;
                char_data <= next_item.beat;
            end
        end
    end

    // The line receiver stalls for a random time after each beat, except in one
    // stretch out of four. When the stimulus asks for it, the receiver holds
    // off for a long stretch. The sender keeps offering characters during that
    // time, so the job queue fills and the framer has to stall its input.
    always @(posedge clk or negedge rst_n)
    begin : pace_line
        int pause;
        if (!rst_n)
        begin
            line_ready <= 1'b0;
            ready_wait <= 1;
        end
        else if (line_valid && line_ready)
        begin
            line_beats++;
            if (holds_started < hold_requests)
            begin
                holds_started++;
                pause = HOLD_OFF_CYCLES;
            end
            else if ((line_beats / 60) % 4 == 2)
                pause = 0;
            else
                pause = $urandom_range(0, 7);
            if (pause != 0)
            begin
                line_ready <= 1'b0;
                ready_wait <= pause;
            end
        end
        else if (!line_ready)
        begin
            if (ready_wait <= 1)
                line_ready <= 1'b1;
            ready_wait <= ready_wait - 1;
        end
    end

    // The predictor and the checker share one block. A character beat is
    // turned into expected bytes before any line beat of the same edge is
    // compared, so the order of processes within a time step cannot matter.
    always @(posedge clk)
    begin : check_line
        line_beat_t want;
        if (rst_n)
        begin
            if (char_valid && char_ready)
                frame_character(char_data);
            if (line_valid && line_ready)
            begin
                if (line_bytes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected line beat: got byte %h last %b too_long %b",
                             $time, line_data.line_byte, line_data.frame_last,
                             line_data.too_long);
                end
                else
                begin
                    want = line_bytes_due.pop_front();
                    if (line_data.line_byte !== want.line_byte ||
                        line_data.frame_last !== want.frame_last ||
                        line_data.too_long !== want.too_long)
                    begin
                        mismatches++;
                        $display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 $time, want.line_byte, want.frame_last, want.too_long,
                                 line_data.line_byte, line_data.frame_last,
                                 line_data.too_long);
                    end
                end
            end
            bytes_due_count <= line_bytes_due.size();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic push_char(input logic [6:0] value, input bit last, input bit hold);
        char_item_t item;
        item.beat.char_in = value;
        item.beat.char_last = last;
        item.wait_for_drain = hold;
        chars_to_send.push_back(item);
    endtask

    task automatic queue_random_message(input int len, input bit hold);
        for (int i = 0; i < len; i++)
            push_char(7'($urandom_range(0, 127)), i == len - 1, hold && i == 0);
    endtask

    // Idle here means that no character is left to send and no byte is due.
    // The check runs on the falling edge, after every update of the rising
    // edge. The settle time then covers a frame that ended with no byte at all.
    task automatic wait_until_idle();
        do
            @(negedge clk);
        while (chars_to_send.size() != 0 || char_valid || line_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // This writes all three registers and then the unused index, one write
    // per edge, with the write enable held high throughout.
    task automatic apply_setting(input cfg_t setting);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CHECK_ENABLE;
        cfg_data <= setting.check_enable;
        @(posedge clk);
        cfg_index <= CFG_SPOIL_START;
        cfg_data <= setting.spoil_start;
        @(posedge clk);
        cfg_index <= CFG_OMIT_END;
        cfg_data <= setting.omit_end;
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data <= 1'($urandom_range(0, 1));
        @(posedge clk);
        cfg_we <= 1'b0;
        framer_cfg = setting;
    endtask

    initial
    begin
        int  queued;
        int  len;
        int  pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The directed frames run at the reset setting: the largest and the
        // zero character each alone, a frame of exactly one slice whose XOR is
        // zero, and a frame of one full slice plus one character. The sender
        // waits for a full drain before the third frame.
        @(negedge clk);
        push_char(7'h7F, 1'b1, 1'b0);
        push_char(7'h00, 1'b1, 1'b0);
        push_char(7'h01, 1'b0, 1'b1);
        push_char(7'h02, 1'b0, 1'b0);
        push_char(7'h04, 1'b0, 1'b0);
        push_char(7'h08, 1'b0, 1'b0);
        push_char(7'h10, 1'b0, 1'b0);
        push_char(7'h20, 1'b0, 1'b0);
        push_char(7'h40, 1'b0, 1'b0);
        push_char(7'h7F, 1'b1, 1'b0);
        push_char(7'h7E, 1'b0, 1'b0);
        push_char(7'h01, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++)
            push_char(7'h00, 1'b0, 1'b0);
        push_char(7'h23, 1'b1, 1'b0);
        wait_until_idle();

        for (int p = 0; p < 7; p++)
        begin
            apply_setting(PHASE_CFG[p]);
            @(negedge clk);
            if (p == 1 || p == 4)
                hold_requests++;
            // Most phases open with a long message near the payload limit. With
            // no checks and no end byte the message always overruns, so its
            // dropped final character leaves nothing to send. One phase hits
            // the limit exactly. Two phases carry only shorter messages.
            if (!PHASE_CFG[p].check_enable && PHASE_CFG[p].omit_end)
                len = $urandom_range(65, 70);
            else if (p == 2)
                len = MAX_PAYLOAD;
            else if (p == 1 || p == 5)
                len = 0;
            else
                len = $urandom_range(62, 72);
            if (len != 0)
                queue_random_message(len, 1'($urandom_range(0, 1)));
            queued = len;
            while (queued < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    len = $urandom_range(1, 10);
                else if (pick < 9)
                    len = $urandom_range(11, 30);
                else
                    len = $urandom_range(31, 48);
                queue_random_message(len, $urandom_range(0, 7) == 0);
                queued += len;
            end
            wait_until_idle();
        end

        if (mismatches == 0 && line_bytes_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fxc_pkg.sv
hw/rtl/fxc_front.sv
hw/rtl/fxc_queue.sv
hw/rtl/fxc_back.sv
hw/rtl/framer_with_slice_xor_check_unit.sv
hw/rtl/fxc_checker.sv
test/testbench.sv
